@@ design/gbd_pkg.sv @@
// gbd_pkg: shared types and constants for the Gaussian basis bank.
// Also holds the elaboration-time helpers that build the exp(-x) table.
// No dependencies.
package gbd_pkg;

    localparam int IDX_W   = 3;
    localparam int PHASE_W = 18;
    localparam int K_W     = 16;
    localparam int VAL_W   = 32;
    localparam int TBL_W   = 31;   // table entries in Q30, entry 0 is 2^30

    // derivative order codes
    localparam logic [1:0] ORD_VALUE  = 2'd0;
    localparam logic [1:0] ORD_FIRST  = 2'd1;
    localparam logic [1:0] ORD_SECOND = 2'd2;
    localparam logic [1:0] ORD_BAD    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_INV_SIGMA_SQ = 3'd0;
    localparam logic [2:0] REG_CENTER_A     = 3'd1;
    localparam logic [2:0] REG_CENTER_B     = 3'd2;
    localparam logic [2:0] REG_CENTER_C     = 3'd3;
    localparam logic [2:0] REG_CENTER_D     = 3'd4;
    localparam logic [2:0] REG_CENTER_E     = 3'd5;

    // control tag that travels with each beat down the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [1:0]       order;
        logic             last;
        logic             err;
        logic             dpos;   // t - c > 0
    } tag_t;

    // restoring divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-16/depth) in Q30 from a 25-term series in Q40
    function automatic logic [TBL_W-1:0] exp_ratio(input int depth);
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] r30;
        mag = 64'd1 << 40;
        sum = 64'd1 << 40;
        for (int n = 1; n <= 24; n++) begin
            mag = udiv64(mag * 64'd16, 64'(depth) * 64'(n));
            if (n % 2 == 1)
                sum = sum - mag;
            else
                sum = sum + mag;
        end
        r30 = (sum + (64'd1 << 9)) >> 10;
        return r30[TBL_W-1:0];
    endfunction

endpackage

@@ design/gaussian_basis_with_derivatives.sv @@
// gaussian_basis_with_derivatives: top level of the Gaussian basis bank.
// Uses gbd_pkg and gbd_exp_rom.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid, in_stall, phase, deriv_order           | in
//  output  | out_valid, out_stall, basis_index, basis_value,  | out
//          | saturated, order_error, last_of_run              |
//  config  | psel, penable, pwrite, paddr, pwdata, prdata     | APB
//
// One input beat gives NUM_CENTERS result beats (one for a bad order), issued one per
// cycle by the center sequencer while the output is not stalled, into the eight-stage
// pipeline; a new input is taken only once the previous one has issued its last beat.
// Reset clears the registers to their defaults and empties the pipeline.
// A stall with out_valid high freezes the whole pipeline; nothing is dropped or repeated.
module gaussian_basis_with_derivatives #(
    parameter int NUM_CENTERS     = 5,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gbd_pkg::PHASE_W-1:0]  phase,
    input  logic [1:0]                          deriv_order,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gbd_pkg::IDX_W-1:0]           basis_index,
    output logic signed [gbd_pkg::VAL_W-1:0]    basis_value,
    output logic                                saturated,
    output logic                                order_error,
    output logic                                last_of_run,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    localparam int AW   = $clog2(EXP_TABLE_DEPTH);
    localparam int PW   = gbd_pkg::PHASE_W;
    localparam int KW   = gbd_pkg::K_W;
    localparam int IW   = gbd_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CENTERS - 1);

    // ---------------- configuration registers ----------------
    logic [KW-1:0]        k_reg;
    logic signed [PW-1:0] cen_reg [5];
    logic                 wr_en;
    logic [2:0]           wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= KW'(4096);
            cen_reg[0] <= PW'(0);
            cen_reg[1] <= PW'(4096);
            cen_reg[2] <= PW'(8192);
            cen_reg[3] <= PW'(12288);
            cen_reg[4] <= PW'(16384);
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                gbd_pkg::REG_INV_SIGMA_SQ: k_reg      <= pwdata[KW-1:0];
                gbd_pkg::REG_CENTER_A:     cen_reg[0] <= pwdata[PW-1:0];
                gbd_pkg::REG_CENTER_B:     cen_reg[1] <= pwdata[PW-1:0];
                gbd_pkg::REG_CENTER_C:     cen_reg[2] <= pwdata[PW-1:0];
                gbd_pkg::REG_CENTER_D:     cen_reg[3] <= pwdata[PW-1:0];
                gbd_pkg::REG_CENTER_E:     cen_reg[4] <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (wr_idx)
            gbd_pkg::REG_INV_SIGMA_SQ: prdata = {16'b0, k_reg};
            gbd_pkg::REG_CENTER_A:     prdata = 32'(cen_reg[0]);
            gbd_pkg::REG_CENTER_B:     prdata = 32'(cen_reg[1]);
            gbd_pkg::REG_CENTER_C:     prdata = 32'(cen_reg[2]);
            gbd_pkg::REG_CENTER_D:     prdata = 32'(cen_reg[3]);
            gbd_pkg::REG_CENTER_E:     prdata = 32'(cen_reg[4]);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || !out_stall;

    // ---------------- center sequencer ----------------
    logic                 busy_reg;
    logic [IW-1:0]        cnt_reg;
    logic signed [PW-1:0] t_reg;
    logic [1:0]           ord_reg;
    logic                 accept;
    logic                 issue;
    logic signed [PW-1:0] cur_t;
    logic [1:0]           cur_ord;
    logic [IW-1:0]        cur_idx;
    logic signed [PW-1:0] cur_c;
    logic                 cur_err;
    logic                 cur_last;

    assign in_stall = !en || busy_reg;
    assign accept   = in_valid && !in_stall;
    assign issue    = accept || (busy_reg && en);
    assign cur_t    = busy_reg ? t_reg : phase;
    assign cur_ord  = busy_reg ? ord_reg : deriv_order;
    assign cur_idx  = busy_reg ? cnt_reg : '0;
    assign cur_err  = (cur_ord == gbd_pkg::ORD_BAD);
    assign cur_last = cur_err || (cur_idx == LAST_IDX);

    always_comb
    begin
        case (cur_idx)
            3'd0:    cur_c = cen_reg[0];
            3'd1:    cur_c = cen_reg[1];
            3'd2:    cur_c = cen_reg[2];
            3'd3:    cur_c = cen_reg[3];
            3'd4:    cur_c = cen_reg[4];
            default: cur_c = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (issue)
        begin
            busy_reg <= !cur_last;
            cnt_reg  <= cur_idx + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg   <= phase;
            ord_reg <= deriv_order;
        end
    end

    // ---------------- valid and tag pipe ----------------
    logic              vld_reg [1:7];
    gbd_pkg::tag_t     tag_reg [1:7];
    gbd_pkg::tag_t     tag0;
    logic signed [PW:0] d0;

    assign d0        = PW'(0) + {cur_t[PW-1], cur_t} - {cur_c[PW-1], cur_c};
    assign tag0.index = cur_idx;
    assign tag0.order = cur_ord;
    assign tag0.last  = cur_last;
    assign tag0.err   = cur_err;
    assign tag0.dpos  = !d0[PW] && (d0 != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 7; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= issue;
            for (int s = 2; s <= 7; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[1] <= tag0;
            for (int s = 2; s <= 7; s++)
                tag_reg[s] <= tag_reg[s-1];
        end
    end

    // ---------------- stage 1: |d| and width ----------------
    logic [PW:0]   ad1_reg;
    logic [KW-1:0] k1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad1_reg <= d0[PW] ? (PW+1)'(-d0) : (PW+1)'(d0);
            k1_reg  <= k_reg;
        end
    end

    // ---------------- stage 2: d*d ----------------
    logic [2*PW+1:0] sq2_reg;
    logic [PW:0]     ad2_reg;
    logic [KW-1:0]   k2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq2_reg <= ad1_reg * ad1_reg;
            ad2_reg <= ad1_reg;
            k2_reg  <= k1_reg;
        end
    end

    // ---------------- stage 3: d*d*k and |d|*k ----------------
    logic [53:0]   prod3_reg;
    logic [34:0]   m3_reg;
    logic [KW-1:0] k3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod3_reg <= 54'(sq2_reg) * 54'(k2_reg);
            m3_reg    <= 35'(ad2_reg) * 35'(k2_reg);
            k3_reg    <= k2_reg;
        end
    end

    // ---------------- stage 4: table address, d*d*k*k ----------------
    logic [63:0]   pos3;
    logic [56:0]   kk3;
    logic [AW-1:0] addr3;
    logic [15:0]   f4_reg;
    logic          big4_reg;
    logic [36:0]   v4_reg;
    logic [34:0]   m4_reg;
    logic [KW-1:0] k4_reg;
    logic [gbd_pkg::TBL_W-1:0] tlo4;
    logic [gbd_pkg::TBL_W-1:0] thi4;

    assign pos3  = {23'b0, prod3_reg[40:0]} * 64'(EXP_TABLE_DEPTH);
    assign kk3   = {16'b0, prod3_reg[40:0]} * 57'(k3_reg) + (57'd1 << 19);
    assign addr3 = pos3[41 +: AW];

    gbd_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (
        .clk    (clk),
        .en     (en),
        .addr   (addr3),
        .lo_reg (tlo4),
        .hi_reg (thi4)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f4_reg   <= pos3[40:25];
            big4_reg <= |prod3_reg[53:41];
            v4_reg   <= kk3[56:20];
            m4_reg   <= m3_reg;
            k4_reg   <= k3_reg;
        end
    end

    // ---------------- stage 5: interpolation product, second-order factor ----------------
    logic signed [38:0] q4;
    logic [46:0]        dif5_reg;
    logic [gbd_pkg::TBL_W-1:0] tlo5_reg;
    logic               big5_reg;
    logic [37:0]        aq5_reg;
    logic               qneg5_reg;
    logic [34:0]        m5_reg;

    assign q4 = $signed({2'b0, v4_reg}) - $signed({7'b0, k4_reg, 16'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dif5_reg  <= 47'(tlo4 - thi4) * 47'(f4_reg);
            tlo5_reg  <= tlo4;
            big5_reg  <= big4_reg;
            aq5_reg   <= q4[38] ? 38'(-q4) : 38'(q4);
            qneg5_reg <= q4[38];
            m5_reg    <= m4_reg;
        end
    end

    // ---------------- stage 6: g in Q30 and Q24 ----------------
    logic [46:0]        corr5;
    logic [30:0]        g30_5;
    logic [30:0]        g30_6_reg;
    logic [24:0]        g24_6_reg;
    logic               big6_reg;
    logic [37:0]        aq6_reg;
    logic               qneg6_reg;
    logic [34:0]        m6_reg;

    assign corr5 = (dif5_reg + 47'h8000) >> 16;
    assign g30_5 = tlo5_reg - corr5[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g30_6_reg <= g30_5;
            g24_6_reg <= 25'((32'(g30_5) + 32'd32) >> 6);
            big6_reg  <= big5_reg;
            aq6_reg   <= aq5_reg;
            qneg6_reg <= qneg5_reg;
            m6_reg    <= m5_reg;
        end
    end

    // ---------------- stage 7: derivative product ----------------
    logic [37:0] op6;
    logic [62:0] mag7_reg;
    logic        neg7_reg;
    logic        big7_reg;

    assign op6 = (tag_reg[6].order == gbd_pkg::ORD_FIRST) ? {3'b0, m6_reg} : aq6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big7_reg <= big6_reg;
            if (tag_reg[6].order == gbd_pkg::ORD_VALUE)
            begin
                mag7_reg <= 63'(g30_6_reg);
                neg7_reg <= 1'b0;
            end
            else
            begin
                mag7_reg <= 63'(g24_6_reg) * 63'(op6);
                neg7_reg <= (tag_reg[6].order == gbd_pkg::ORD_FIRST) ? tag_reg[6].dpos
                                                                      : qneg6_reg;
            end
        end
    end

    // ---------------- output stage: round, sign, clip ----------------
    logic [63:0] rnd7;
    logic        sat7;
    logic [31:0] val7;

    always_comb
    begin
        case (tag_reg[7].order)
            gbd_pkg::ORD_VALUE: rnd7 = (64'(mag7_reg) + (64'd1 << 13)) >> 14;
            gbd_pkg::ORD_FIRST: rnd7 = (64'(mag7_reg) + (64'd1 << 29)) >> 30;
            default:            rnd7 = (64'(mag7_reg) + (64'd1 << 31)) >> 32;
        endcase
        sat7 = 1'b0;
        val7 = '0;
        if (!tag_reg[7].err && !big7_reg)
        begin
            if (neg7_reg)
            begin
                if (rnd7 > 64'h8000_0000)
                begin
                    sat7 = 1'b1;
                    val7 = 32'h8000_0000;
                end
                else
                    val7 = 32'(-rnd7);
            end
            else
            begin
                if (rnd7 > 64'h7FFF_FFFF)
                begin
                    sat7 = 1'b1;
                    val7 = 32'h7FFF_FFFF;
                end
                else
                    val7 = rnd7[31:0];
            end
        end
    end

    logic [IW-1:0] idx_o_reg;
    logic [31:0]   val_o_reg;
    logic          sat_o_reg;
    logic          err_o_reg;
    logic          last_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[7];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_o_reg  <= tag_reg[7].index;
            val_o_reg  <= val7;
            sat_o_reg  <= sat7;
            err_o_reg  <= tag_reg[7].err;
            last_o_reg <= tag_reg[7].last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign basis_index = idx_o_reg;
    assign basis_value = $signed(val_o_reg);
    assign saturated   = sat_o_reg;
    assign order_error = err_o_reg;
    assign last_of_run = last_o_reg;

    // ---------------- assertions ----------------
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && order_error |-> last_of_run && basis_value == 0 && !saturated)
        else $error("error beat malformed");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("input taken while centers still issuing");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (basis_value == 32'sh7FFF_FFFF || basis_value == 32'sh8000_0000))
        else $error("saturated flag without clipped value");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> vld_reg[7] == $past(vld_reg[7]))
        else $error("pipeline moved during output stall");
endmodule

@@ design/gbd_exp_rom.sv @@
// gbd_exp_rom: exp(-x) table over x in [0,16], Q30, depth+1 entries.
// Reads entries addr and addr+1 together, registered. Uses gbd_pkg.
module gbd_exp_rom #(
    parameter int DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [$clog2(DEPTH)-1:0]    addr,
    output logic [gbd_pkg::TBL_W-1:0]   lo_reg,
    output logic [gbd_pkg::TBL_W-1:0]   hi_reg
);
    localparam int AW = $clog2(DEPTH);
    localparam int W  = gbd_pkg::TBL_W;

    function automatic logic [(DEPTH+1)*W-1:0] build_table();
        logic [(DEPTH+1)*W-1:0] tb;
        logic [63:0]            prev;
        logic [63:0]            r30;
        tb   = '0;
        r30  = 64'(gbd_pkg::exp_ratio(DEPTH));
        prev = 64'd1 << 30;
        tb[0 +: W] = prev[W-1:0];
        for (int i = 1; i <= DEPTH; i++) begin
            prev = (prev * r30 + (64'd1 << 29)) >> 30;
            tb[i*W +: W] = prev[W-1:0];
        end
        return tb;
    endfunction

    localparam logic [(DEPTH+1)*W-1:0] TABLE_BITS = build_table();

    logic [AW:0] addr_lo;
    logic [AW:0] addr_hi;

    assign addr_lo = {1'b0, addr};
    assign addr_hi = {1'b0, addr} + 1'b1;

    // registered read of the interpolation pair
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= TABLE_BITS[addr_lo*W +: W];
            hi_reg <= TABLE_BITS[addr_hi*W +: W];
        end
    end
endmodule

@@ verif/tb_gaussian_basis_with_derivatives.sv @@
// tb_gaussian_basis_with_derivatives: self-checking bench for the Gaussian basis bank.
// Drives phase/order beats and APB register writes, predicts every result beat in-line.
// Depends on gbd_pkg and gaussian_basis_with_derivatives.
module tb_gaussian_basis_with_derivatives;

    localparam int NCTR  = 5;
    localparam int DEPTH = 256;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [gbd_pkg::IDX_W-1:0] index;
        logic [gbd_pkg::VAL_W-1:0] value;
        logic                      sat;
        logic                      err;
        logic                      last;
    } basis_beat_t;

    typedef struct {
        logic [gbd_pkg::PHASE_W-1:0] ph;
        logic [1:0]                  ord;
        logic                        has_gold;
        logic [gbd_pkg::VAL_W-1:0]   gold;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [gbd_pkg::PHASE_W-1:0] phase = '0;
    logic [1:0] deriv_order = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [gbd_pkg::IDX_W-1:0] basis_index;
    logic signed [gbd_pkg::VAL_W-1:0] basis_value;
    logic saturated, order_error, last_of_run;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gaussian_basis_with_derivatives #(.NUM_CENTERS(NCTR), .EXP_TABLE_DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .phase(phase), .deriv_order(deriv_order),
        .out_valid(out_valid), .out_stall(out_stall),
        .basis_index(basis_index), .basis_value(basis_value),
        .saturated(saturated), .order_error(order_error), .last_of_run(last_of_run),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the register file and the exp table
    logic [15:0]                 k_reg;
    logic [gbd_pkg::PHASE_W-1:0] ctr_reg [NCTR];
    logic [63:0]                 exp_tbl [DEPTH+1];

    basis_beat_t expected_beats[$];
    logic [gbd_pkg::VAL_W-1:0] gold_vals[$];
    logic                      gold_used[$];
    int  errors = 0;
    int  cycles = 0;
    bit  long_hold = 1'b0;

    function automatic logic [63:0] exp_step_ratio();
        logic [63:0] mag, sum;
        mag = 64'd1 << 40;
        sum = 64'd1 << 40;
        for (int n = 1; n <= 24; n++)
        begin
            mag = (mag * 64'd16) / (64'(DEPTH) * 64'(n));
            if (n % 2 == 1) sum = sum - mag;
            else sum = sum + mag;
        end
        return (sum + (64'd1 << 9)) >> 10;
    endfunction

    // magnitude rounded half away from zero, signed and clipped to 32 bits
    function automatic logic [32:0] round_clip(logic [63:0] mag, bit neg, int sh);
        logic [63:0] q;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg)
        begin
            if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
            return {1'b0, 32'(-q)};
        end
        if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, q[31:0]};
    endfunction

    task automatic predict_basis(logic [gbd_pkg::PHASE_W-1:0] ph, logic [1:0] ord);
        logic signed [63:0] t, c, d, q;
        logic [63:0] ad, prod, pos, idx, f, g30, g24, v, aq, k;
        logic [32:0] r;
        basis_beat_t b;
        if (ord == gbd_pkg::ORD_BAD)
        begin
            b = '{index: '0, value: '0, sat: 1'b0, err: 1'b1, last: 1'b1};
            expected_beats = {expected_beats, b};
            return;
        end
        k = 64'(k_reg);
        t = 64'(signed'(ph));
        for (int i = 0; i < NCTR; i++)
        begin
            c = 64'(signed'(ctr_reg[i]));
            d = t - c;
            ad = (d < 0) ? -d : d;
            prod = ad * ad * k;
            r = '0;
            if (prod < (64'd1 << 41))
            begin
                pos = prod * DEPTH;
                idx = pos >> 41;
                f = (pos >> 25) & 64'hFFFF;
                if (idx >= DEPTH) idx = DEPTH - 1;
                g30 = exp_tbl[idx] - (((exp_tbl[idx] - exp_tbl[idx+1]) * f + 64'h8000) >> 16);
                g24 = (g30 + 32) >> 6;
                if (ord == gbd_pkg::ORD_VALUE)
                    r = round_clip(g30, 1'b0, 14);
                else if (ord == gbd_pkg::ORD_FIRST)
                    r = round_clip(g24 * (ad * k), d > 0, 30);
                else
                begin
                    v = (prod * k + (64'd1 << 19)) >> 20;
                    q = signed'(v) - signed'(k << 16);
                    aq = (q < 0) ? -q : q;
                    r = round_clip(g24 * aq, q < 0, 32);
                end
            end
            b = '{index: gbd_pkg::IDX_W'(i), value: r[31:0], sat: r[32], err: 1'b0,
                  last: (i == NCTR - 1)};
            expected_beats = {expected_beats, b};
        end
    endtask

    // APB write, idle only
    task automatic reg_write(logic [2:0] ridx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {ridx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (ridx == gbd_pkg::REG_INV_SIGMA_SQ) k_reg = val[15:0];
        else ctr_reg[ridx - 1] = val[gbd_pkg::PHASE_W-1:0];
    endtask

    task automatic drain_pipe();
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // one beat; sender gaps come from the burst logic in the caller
    task automatic send_beat(logic [gbd_pkg::PHASE_W-1:0] ph, logic [1:0] ord,
                             bit has_gold, logic [gbd_pkg::VAL_W-1:0] gold);
        in_valid <= 1'b1;
        phase <= ph;
        deriv_order <= ord;
        predict_basis(ph, ord);
        gold_used = {gold_used, has_gold};
        gold_vals = {gold_vals, gold};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [gbd_pkg::PHASE_W-1:0] rand_phase();
        case ($urandom_range(0, 3))
            0: return gbd_pkg::PHASE_W'($urandom);
            1: return gbd_pkg::PHASE_W'(ctr_reg[$urandom_range(0, NCTR-1)]
                                        + $urandom_range(0, 4095) - 2048);
            2: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            default: return gbd_pkg::PHASE_W'($urandom_range(0, 20000) - 2000);
        endcase
    endfunction

    task automatic random_phase_run(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
                burst = $urandom_range(1, 20);
            end
            burst--;
            send_beat(rand_phase(),
                      ($urandom_range(0, 9) == 0) ? gbd_pkg::ORD_BAD
                                                  : 2'($urandom_range(0, 2)),
                      1'b0, '0);
        end
        in_valid <= 1'b0;
    endtask

    // receiver stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        if (long_hold)
            out_stall <= 1'b1;
        else
            case ((cycles / 300) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
    end

    // result checker
    always @(posedge clk)
    begin
        basis_beat_t exp_b;
        bit g_on;
        logic [gbd_pkg::VAL_W-1:0] g_val;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat idx=%0d val=%h", $time, basis_index, basis_value);
                errors++;
            end
            else
            begin
                exp_b = expected_beats.pop_front();
                if (basis_index !== exp_b.index || basis_value !== exp_b.value ||
                    saturated !== exp_b.sat || order_error !== exp_b.err ||
                    last_of_run !== exp_b.last)
                begin
                    $display("%0t: mismatch exp idx=%0d val=%h sat=%b err=%b last=%b",
                             $time, exp_b.index, exp_b.value, exp_b.sat, exp_b.err, exp_b.last);
                    $display("%0t:          got idx=%0d val=%h sat=%b err=%b last=%b",
                             $time, basis_index, basis_value, saturated, order_error,
                             last_of_run);
                    errors++;
                end
                // typed-in value checks the first beat of a directed row
                if (exp_b.index == 0 && gold_used.size() != 0)
                begin
                    g_on = gold_used.pop_front();
                    g_val = gold_vals.pop_front();
                    if (g_on && basis_value !== g_val)
                    begin
                        $display("%0t: table value exp=%h got=%h", $time, g_val, basis_value);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("[gaussian_basis_with_derivatives] ERROR");
            $finish;
        end
    end

    stim_row_t dir_rows[] = '{
        '{18'h00000, gbd_pkg::ORD_VALUE,  1'b1, 32'h0001_0000},
        '{18'h00000, gbd_pkg::ORD_FIRST,  1'b1, 32'h0000_0000},
        '{18'h00000, gbd_pkg::ORD_SECOND, 1'b0, '0},
        '{18'h00000, gbd_pkg::ORD_BAD,    1'b1, 32'h0000_0000},
        '{18'h1FFFF, gbd_pkg::ORD_VALUE,  1'b0, '0},
        '{18'h20000, gbd_pkg::ORD_VALUE,  1'b0, '0},
        '{18'h1FFFF, gbd_pkg::ORD_FIRST,  1'b0, '0},
        '{18'h20000, gbd_pkg::ORD_SECOND, 1'b0, '0},
        '{18'h01000, gbd_pkg::ORD_FIRST,  1'b0, '0},
        '{18'h02800, gbd_pkg::ORD_SECOND, 1'b0, '0},
        '{18'h3F000, gbd_pkg::ORD_FIRST,  1'b0, '0},
        '{18'h3FFFF, gbd_pkg::ORD_BAD,    1'b1, 32'h0000_0000},
        '{18'h15555, gbd_pkg::ORD_SECOND, 1'b0, '0},
        '{18'h2AAAA, gbd_pkg::ORD_FIRST,  1'b0, '0}
    };

    initial
    begin
        logic [63:0] r30;
        r30 = exp_step_ratio();
        exp_tbl[0] = 64'd1 << 30;
        for (int i = 1; i <= DEPTH; i++)
            exp_tbl[i] = (exp_tbl[i-1] * r30 + (64'd1 << 29)) >> 30;
        k_reg = 16'd4096;
        ctr_reg = '{18'd0, 18'd4096, 18'd8192, 18'd12288, 18'd16384};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings
        foreach (dir_rows[i])
            send_beat(dir_rows[i].ph, dir_rows[i].ord, dir_rows[i].has_gold, dir_rows[i].gold);
        in_valid <= 1'b0;
        drain_pipe();

        // extremes: widest and narrowest kernel, centers at range ends and around zero
        reg_write(gbd_pkg::REG_INV_SIGMA_SQ, 32'd1);
        reg_write(gbd_pkg::REG_CENTER_A, 32'h0002_0000);
        reg_write(gbd_pkg::REG_CENTER_B, 32'h0001_FFFF);
        reg_write(gbd_pkg::REG_CENTER_E, 32'h0000_0000);
        random_phase_run(30);
        drain_pipe();
        reg_write(gbd_pkg::REG_INV_SIGMA_SQ, 32'hFFFF);
        reg_write(gbd_pkg::REG_CENTER_C, 32'h0003_FFFF);
        reg_write(gbd_pkg::REG_CENTER_D, 32'h0000_0001);
        random_phase_run(30);
        drain_pipe();

        // zero inverse-sigma-squared register case, then random settings
        reg_write(gbd_pkg::REG_INV_SIGMA_SQ, 32'd0);
        random_phase_run(15);
        drain_pipe();
        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(gbd_pkg::REG_INV_SIGMA_SQ,
                      $urandom_range(1, 3) == 1 ? $urandom_range(1, 65535)
                                                : $urandom_range(16, 4096));
            for (int c = 0; c < NCTR; c++)
                reg_write(3'(gbd_pkg::REG_CENTER_A + c), $urandom);
            if (ph == 1)
            begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (200) @(posedge clk);
                        long_hold = 1'b0;
                    end
                    random_phase_run(45);
                join
            end
            else
                random_phase_run(45);
            drain_pipe();
        end

        if (errors == 0 && expected_beats.size() == 0)
            $display("[gaussian_basis_with_derivatives] OK");
        else
            $display("[gaussian_basis_with_derivatives] ERROR");
        $finish;
    end
endmodule
